// File: src/lscn_pkg.sv
package lscn_pkg;

	localparam int LSCN_NUM_SENSORS = 6;
	localparam int LSCN_IDX_W       = $clog2(LSCN_NUM_SENSORS);
	localparam int LSCN_RAW_W       = 16;
	localparam int LSCN_LEVEL_W     = 10;
	// |raw - min| * 1000 stays below 2**26
	localparam int LSCN_NUM_W       = 26;
	localparam int LSCN_DIV_STEPS   = LSCN_LEVEL_W;
	localparam int LSCN_CNT_W       = $clog2(LSCN_DIV_STEPS);

	localparam logic [LSCN_RAW_W-1:0]   LSCN_RAW_MAX    = 16'hFFFF;
	localparam logic [LSCN_RAW_W-1:0]   LSCN_MARGIN_RST = 16'h1000;
	localparam logic [LSCN_LEVEL_W-1:0] LSCN_LEVEL_FULL = 10'd1000;

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_UPDATE  = 2'd1,
		OP_MEASURE = 2'd2,
		OP_NONE    = 2'd3
	} lscn_op_t;

	typedef struct packed {
		logic                  clear;
		logic                  update;
		logic [LSCN_IDX_W-1:0] idx;
	} lscn_store_ctl_t;

endpackage

// File: src/lscn_cal_store.sv
module lscn_cal_store (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lscn_pkg::lscn_store_ctl_t       ctl,
	input  logic [lscn_pkg::LSCN_RAW_W-1:0] raw,
	output logic [lscn_pkg::LSCN_RAW_W-1:0] lo,
	output logic [lscn_pkg::LSCN_RAW_W-1:0] hi
);
	import lscn_pkg::*;

	logic [LSCN_RAW_W-1:0] min_q [LSCN_NUM_SENSORS];
	logic [LSCN_RAW_W-1:0] max_q [LSCN_NUM_SENSORS];

	// clear sets every channel at once; update widens only the addressed one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LSCN_NUM_SENSORS; i++) begin
				min_q[i] <= LSCN_RAW_MAX;
				max_q[i] <= '0;
			end
		end else if (ctl.clear) begin
			for (int i = 0; i < LSCN_NUM_SENSORS; i++) begin
				min_q[i] <= LSCN_RAW_MAX;
				max_q[i] <= '0;
			end
		end else if (ctl.update) begin
			if (raw < min_q[ctl.idx]) min_q[ctl.idx] <= raw;
			if (raw > max_q[ctl.idx]) max_q[ctl.idx] <= raw;
		end
	end

	assign lo = min_q[ctl.idx];
	assign hi = max_q[ctl.idx];

endmodule

// File: src/lscn_div.sv
module lscn_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [lscn_pkg::LSCN_NUM_W-1:0]   num,
	input  logic [lscn_pkg::LSCN_RAW_W-1:0]   den,
	output logic                              done,
	output logic [lscn_pkg::LSCN_LEVEL_W-1:0] quot
);
	import lscn_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [LSCN_CNT_W-1:0]   cnt_q;
	logic [LSCN_NUM_W-1:0]   rem_q;
	logic [LSCN_NUM_W-1:0]   den_sh_q;
	logic [LSCN_LEVEL_W-1:0] quot_q;
	logic [LSCN_NUM_W:0]     trial;
	logic                    fits;

	// restoring division, one quotient bit per cycle, MSB first;
	// caller guarantees num < den * 2**LSCN_DIV_STEPS
	assign trial = {1'b0, rem_q} - {1'b0, den_sh_q};
	assign fits  = !trial[LSCN_NUM_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= LSCN_CNT_W'(LSCN_DIV_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q    <= num;
			den_sh_q <= LSCN_NUM_W'(den) << (LSCN_DIV_STEPS - 1);
			quot_q   <= '0;
		end else if (busy_q) begin
			quot_q   <= {quot_q[LSCN_LEVEL_W-2:0], fits};
			den_sh_q <= den_sh_q >> 1;
			if (fits) rem_q <= trial[LSCN_NUM_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: src/line_sensor_calibrate_normalize_core.sv
// Channel  | Handshake               | Payload
// ---------+-------------------------+----------------------------------------
// input    | in_valid / in_stall     | opcode, detect_color, raw_0 .. raw_5
// output   | out_valid / out_stall   | level_0 .. level_5, line_detected
// config   | cfg_wr_en               | cfg_wr_data (detect_margin)
//
// Steps from accept to result: clear and unused opcode go from load to done;
//   calibrate update loads each sensor in turn; measure runs load and multiply
//   per sensor, plus the shared one-bit-per-cycle divider when the level is
//   neither 0 nor full scale; done waits for the output slot, then idle.
// Reset: calibration goes to min 65535 / max 0, margin to 4096, no beat held.
// Stalls: in_stall is high while a beat is in work; a finished result waits
//   in the output register, so a new beat is taken while out_stall holds it.
module line_sensor_calibrate_normalize_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        opcode,
	input  logic                              detect_color,
	input  logic [lscn_pkg::LSCN_RAW_W-1:0]   raw_0,
	input  logic [lscn_pkg::LSCN_RAW_W-1:0]   raw_1,
	input  logic [lscn_pkg::LSCN_RAW_W-1:0]   raw_2,
	input  logic [lscn_pkg::LSCN_RAW_W-1:0]   raw_3,
	input  logic [lscn_pkg::LSCN_RAW_W-1:0]   raw_4,
	input  logic [lscn_pkg::LSCN_RAW_W-1:0]   raw_5,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [lscn_pkg::LSCN_LEVEL_W-1:0] level_0,
	output logic [lscn_pkg::LSCN_LEVEL_W-1:0] level_1,
	output logic [lscn_pkg::LSCN_LEVEL_W-1:0] level_2,
	output logic [lscn_pkg::LSCN_LEVEL_W-1:0] level_3,
	output logic [lscn_pkg::LSCN_LEVEL_W-1:0] level_4,
	output logic [lscn_pkg::LSCN_LEVEL_W-1:0] level_5,
	output logic                              line_detected,
	input  logic                              cfg_wr_en,
	input  logic [lscn_pkg::LSCN_RAW_W-1:0]   cfg_wr_data
);
	import lscn_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOAD = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                  state_q, state_d;
	logic [LSCN_IDX_W-1:0]   idx_q;
	logic                    last_idx;
	logic                    advance;

	// captured beat
	lscn_op_t                op_q;
	logic                    color_q;
	logic [LSCN_RAW_W-1:0]   raw_q [LSCN_NUM_SENSORS];
	logic [LSCN_RAW_W-1:0]   margin_q;

	// per-sensor working values
	logic [LSCN_RAW_W:0]     diff_q;
	logic [LSCN_RAW_W:0]     span_q;
	logic                    seen_q;
	logic [LSCN_LEVEL_W-1:0] lvl_q [LSCN_NUM_SENSORS];

	// output register
	logic                    out_valid_q;
	logic [LSCN_LEVEL_W-1:0] out_level_q [LSCN_NUM_SENSORS];
	logic                    out_line_q;

	lscn_store_ctl_t         store_ctl;
	logic [LSCN_RAW_W-1:0]   cal_lo, cal_hi;
	logic [LSCN_RAW_W-1:0]   raw_k;
	logic [LSCN_RAW_W:0]     diff_k, span_k, black_bound;
	logic                    hit_k;
	logic [LSCN_RAW_W-1:0]   mag_diff, mag_span;
	logic                    lvl_zero, lvl_full;
	logic [LSCN_NUM_W-1:0]   product;
	logic                    div_start, div_done;
	logic [LSCN_LEVEL_W-1:0] div_quot;
	logic                    in_fire, out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign last_idx  = (idx_q == LSCN_IDX_W'(LSCN_NUM_SENSORS - 1));

	// ---------------------------------------------------------------
	// Calibration store, addressed by the sensor sequencer
	// ---------------------------------------------------------------
	always_comb begin
		store_ctl.clear  = (state_q == S_LOAD) && (op_q == OP_CLEAR);
		store_ctl.update = (state_q == S_LOAD) && (op_q == OP_UPDATE);
		store_ctl.idx    = idx_q;
	end

	assign raw_k = raw_q[idx_q];

	lscn_cal_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (store_ctl),
		.raw    (raw_k),
		.lo     (cal_lo),
		.hi     (cal_hi)
	);

	// ---------------------------------------------------------------
	// Per-sensor measure arithmetic
	// ---------------------------------------------------------------
	assign diff_k      = {1'b0, raw_k} - {1'b0, cal_lo};
	assign span_k      = {1'b0, cal_hi} - {1'b0, cal_lo};
	assign black_bound = {1'b0, cal_lo} + {1'b0, margin_q};

	// White bound max - margin is negative when margin exceeds max: never a hit
	always_comb begin
		if (color_q) hit_k = ({1'b0, raw_k} > black_bound);
		else         hit_k = (cal_hi >= margin_q) && (raw_k < cal_hi - margin_q);
	end

	// Magnitudes; both fit 16 bits since |value| <= 65535
	always_comb begin
		logic [LSCN_RAW_W:0] neg_diff, neg_span;
		neg_diff = -diff_q;
		neg_span = -span_q;
		mag_diff = diff_q[LSCN_RAW_W] ? neg_diff[LSCN_RAW_W-1:0] : diff_q[LSCN_RAW_W-1:0];
		mag_span = span_q[LSCN_RAW_W] ? neg_span[LSCN_RAW_W-1:0] : span_q[LSCN_RAW_W-1:0];
	end

	// Level is 0 for an empty range, a zero offset, or a negative quotient.
	// Full scale exactly when |diff| >= |span|; otherwise the quotient is < 1000.
	assign lvl_zero = (span_q == '0) || (diff_q == '0) ||
	                  (diff_q[LSCN_RAW_W] != span_q[LSCN_RAW_W]);
	assign lvl_full = (mag_diff >= mag_span);
	assign product  = LSCN_NUM_W'(mag_diff) * LSCN_NUM_W'(LSCN_LEVEL_FULL);
	assign div_start = (state_q == S_MUL) && !lvl_zero && !lvl_full;

	lscn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (product),
		.den    (mag_span),
		.done   (div_done),
		.quot   (div_quot)
	);

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		advance = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_LOAD;
			end
			S_LOAD: begin
				case (op_q)
					OP_UPDATE:  advance = 1'b1;
					OP_MEASURE: state_d = S_MUL;
					default:    state_d = S_DONE;
				endcase
			end
			S_MUL: begin
				if (div_start) state_d = S_DIV;
				else           advance = 1'b1;
			end
			S_DIV: begin
				if (div_done) advance = 1'b1;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (advance) state_d = last_idx ? S_DONE : S_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			margin_q    <= LSCN_MARGIN_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) margin_q <= cfg_wr_data;
			// step to the next sensor, rewind on a new beat
			if (in_fire)      idx_q <= '0;
			else if (advance) idx_q <= idx_q + 1'b1;
			// load the result when the output slot is free, drop it once taken
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall)              out_valid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// Datapath registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= lscn_op_t'(opcode);
			color_q  <= detect_color;
			raw_q[0] <= raw_0;
			raw_q[1] <= raw_1;
			raw_q[2] <= raw_2;
			raw_q[3] <= raw_3;
			raw_q[4] <= raw_4;
			raw_q[5] <= raw_5;
			seen_q   <= 1'b0;
		end
		if (state_q == S_LOAD && op_q == OP_MEASURE) begin
			diff_q <= diff_k;
			span_q <= span_k;
			if (hit_k) seen_q <= 1'b1;
		end
		if (state_q == S_MUL && !div_start) begin
			lvl_q[idx_q] <= lvl_zero ? '0 : LSCN_LEVEL_FULL;
		end
		if (state_q == S_DIV && div_done) begin
			lvl_q[idx_q] <= div_quot;
		end
		// hold the result until taken; non-measure beats give zeros
		if (state_q == S_DONE && out_free) begin
			for (int i = 0; i < LSCN_NUM_SENSORS; i++) begin
				out_level_q[i] <= (op_q == OP_MEASURE) ? lvl_q[i] : '0;
			end
			out_line_q <= (op_q == OP_MEASURE) && seen_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign level_0       = out_level_q[0];
	assign level_1       = out_level_q[1];
	assign level_2       = out_level_q[2];
	assign level_3       = out_level_q[3];
	assign level_4       = out_level_q[4];
	assign level_5       = out_level_q[5];
	assign line_detected = out_line_q;

endmodule

// File: tb/tb_line_sensor_calibrate_normalize_core.sv
module tb_line_sensor_calibrate_normalize_core;
	timeunit 1ns;
	timeprecision 1ps;

	import lscn_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 9;
	localparam int PHASE_BEATS  = 70;
	localparam int NUM_PHASES   = 6;
	localparam int HOLD_CYCLES  = 3000;
	localparam int TAIL_CYCLES  = 100;
	localparam int REPORT_LIMIT = 10;

	typedef logic [LSCN_NUM_SENSORS-1:0][LSCN_RAW_W-1:0] raw_vec_t;

	// One input beat: opcode, color under test and the six discharge times.
	typedef struct packed {
		lscn_op_t op;
		logic     color;
		raw_vec_t raw;
	} sense_beat_t;

	// One result beat: six normalized levels and the detection flag.
	typedef struct packed {
		logic [LSCN_NUM_SENSORS-1:0][LSCN_LEVEL_W-1:0] level;
		logic                                          detected;
	} level_beat_t;

	// Receiver behaviors, switched at random by the receiver.
	typedef enum int {
		RX_FREE,
		RX_LIGHT,
		RX_HEAVY,
		RX_PERIODIC
	} rx_mode_e;

	// Tracks the calibration state seen by accepted beats and holds the levels
	// each beat must produce, in order.
	class calib_scoreboard;
		logic [LSCN_RAW_W-1:0] cal_min [LSCN_NUM_SENSORS];
		logic [LSCN_RAW_W-1:0] cal_max [LSCN_NUM_SENSORS];
		logic [LSCN_RAW_W-1:0] margin;
		level_beat_t           levels_due[$];
		int                    mismatches;
		int                    results_seen;
		int                    measures;
		int                    detections;

		function new();
			wipe_calibration();
			margin       = LSCN_MARGIN_RST;
			mismatches   = 0;
			results_seen = 0;
			measures     = 0;
			detections   = 0;
		endfunction

		function void wipe_calibration();
			int k;
			for (k = 0; k < LSCN_NUM_SENSORS; k++) begin
				cal_min[k] = LSCN_RAW_MAX;
				cal_max[k] = '0;
			end
		endfunction

		// Signed 32-bit scaling, truncated toward zero, clamped to full scale.
		function int scale_level(int raw, int lo, int hi);
			int full;
			int span;
			int v;
			full = LSCN_LEVEL_FULL;
			span = hi - lo;
			v    = 0;
			if (span != 0)
				v = ((raw - lo) * full) / span;
			if (v < 0)
				v = 0;
			else if (v > full)
				v = full;
			return v;
		endfunction

		function void note_input(sense_beat_t b);
			level_beat_t r;
			int          k;
			int          raw_i;
			int          lo;
			int          hi;
			int          m;
			r = '0;
			case (b.op)
			OP_CLEAR: wipe_calibration();
			OP_UPDATE: begin
				for (k = 0; k < LSCN_NUM_SENSORS; k++) begin
					if (b.raw[k] < cal_min[k])
						cal_min[k] = b.raw[k];
					if (b.raw[k] > cal_max[k])
						cal_max[k] = b.raw[k];
				end
			end
			OP_MEASURE: begin
				measures++;
				m = margin;
				for (k = 0; k < LSCN_NUM_SENSORS; k++) begin
					raw_i      = b.raw[k];
					lo         = cal_min[k];
					hi         = cal_max[k];
					r.level[k] = scale_level(raw_i, lo, hi);
					if (b.color ? (raw_i > lo + m) : (raw_i < hi - m))
						r.detected = 1'b1;
				end
				if (r.detected)
					detections++;
			end
			default: ;
			endcase
			levels_due.push_back(r);
		endfunction

		function void note_mismatch(string field, logic [LSCN_LEVEL_W-1:0] want_v,
				logic [LSCN_LEVEL_W-1:0] got_v);
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
		endfunction

		function void check_result(level_beat_t got);
			level_beat_t want;
			int          k;
			results_seen++;
			if (levels_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%t: result beat with nothing due, detected %0b", $time,
						got.detected);
				return;
			end
			want = levels_due.pop_front();
			for (k = 0; k < LSCN_NUM_SENSORS; k++) begin
				if (got.level[k] !== want.level[k])
					note_mismatch($sformatf("level_%0d", k), want.level[k], got.level[k]);
			end
			if (got.detected !== want.detected)
				note_mismatch("line_detected", want.detected, got.detected);
		endfunction

		function int pending();
			return levels_due.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [1:0]              opcode;
	logic                    detect_color;
	logic [LSCN_RAW_W-1:0]   raw_0, raw_1, raw_2, raw_3, raw_4, raw_5;
	logic                    out_valid;
	logic                    out_stall;
	logic [LSCN_LEVEL_W-1:0] level_0, level_1, level_2, level_3, level_4, level_5;
	logic                    line_detected;
	logic                    cfg_wr_en;
	logic [LSCN_RAW_W-1:0]   cfg_wr_data;

	calib_scoreboard sb = new();

	bit hold_req        = 1'b0;
	int burst_left      = 0;
	int beats_counted   = 0;
	int margins_written = 0;

	line_sensor_calibrate_normalize_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.detect_color  (detect_color),
		.raw_0         (raw_0),
		.raw_1         (raw_1),
		.raw_2         (raw_2),
		.raw_3         (raw_3),
		.raw_4         (raw_4),
		.raw_5         (raw_5),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.level_0       (level_0),
		.level_1       (level_1),
		.level_2       (level_2),
		.level_3       (level_3),
		.level_4       (level_4),
		.level_5       (level_5),
		.line_detected (line_detected),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Present one beat and hold it until the block takes it. Valid stays high
	// on return, so a back-to-back beat simply replaces the payload.
	task automatic send_beat(input sense_beat_t b);
		in_valid     <= 1'b1;
		opcode       <= b.op;
		detect_color <= b.color;
		raw_0        <= b.raw[0];
		raw_1        <= b.raw[1];
		raw_2        <= b.raw[2];
		raw_3        <= b.raw[3];
		raw_4        <= b.raw[4];
		raw_5        <= b.raw[5];
		do @(posedge clk); while (in_stall);
		// Accepted at this edge: record what it must produce.
		sb.note_input(b);
		if (b.op != OP_NONE)
			beats_counted++;
	endtask

	// Send in bursts: at the start of each burst, drop valid for a random gap
	// (or none, so some bursts run straight into the next).
	task automatic offer(input sense_beat_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(40, 1);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_beat(b);
	endtask

	// Drop valid and wait until every result due has come back. Each beat gives
	// exactly one result, so the block is idle after that.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write the detection margin while the block is idle.
	task automatic set_margin(input logic [LSCN_RAW_W-1:0] m);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.margin = m;
		margins_written++;
	endtask

	function automatic sense_beat_t mk_beat(lscn_op_t op, logic color,
			logic [LSCN_RAW_W-1:0] r0, logic [LSCN_RAW_W-1:0] r1,
			logic [LSCN_RAW_W-1:0] r2, logic [LSCN_RAW_W-1:0] r3,
			logic [LSCN_RAW_W-1:0] r4, logic [LSCN_RAW_W-1:0] r5);
		sense_beat_t b;
		b.op     = op;
		b.color  = color;
		b.raw[0] = r0;
		b.raw[1] = r1;
		b.raw[2] = r2;
		b.raw[3] = r3;
		b.raw[4] = r4;
		b.raw[5] = r5;
		return b;
	endfunction

	function automatic raw_vec_t random_raws();
		raw_vec_t v;
		int       k;
		for (k = 0; k < LSCN_NUM_SENSORS; k++)
			v[k] = $urandom_range(65535);
		return v;
	endfunction

	// Pick a discharge time around a center, clipped to the timer range.
	function automatic logic [LSCN_RAW_W-1:0] band_raw(int center, int width);
		int v;
		v = center - width / 2 + int'($urandom_range(width));
		if (v < 0)
			v = 0;
		else if (v > 65535)
			v = 65535;
		return v;
	endfunction

	// Mostly well-formed sessions: optional clear, a few calibration sweeps
	// over one band, then measures over a slightly wider band so levels land
	// inside, below and above the range. The rest is noise with any opcode.
	task automatic run_sequence();
		sense_beat_t b;
		int          center;
		int          width;
		int          n;
		int          k;
		if ($urandom_range(99) < 85) begin
			center = $urandom_range(65535);
			case ($urandom_range(3))
			0: width = 0;
			1: width = $urandom_range(200, 1);
			2: width = $urandom_range(20000, 200);
			default: width = 65535;
			endcase
			if ($urandom_range(9) < 7) begin
				b.op    = OP_CLEAR;
				b.color = $urandom_range(1);
				b.raw   = random_raws();
				offer(b);
			end
			n = $urandom_range(6, 1);
			repeat (n) begin
				b.op    = OP_UPDATE;
				b.color = $urandom_range(1);
				for (k = 0; k < LSCN_NUM_SENSORS; k++)
					b.raw[k] = band_raw(center, width);
				offer(b);
			end
			n = $urandom_range(8, 1);
			repeat (n) begin
				b.op    = OP_MEASURE;
				b.color = $urandom_range(1);
				for (k = 0; k < LSCN_NUM_SENSORS; k++)
					b.raw[k] = band_raw(center, width + width / 2 + $urandom_range(64));
				offer(b);
			end
		end else begin
			n = $urandom_range(4, 1);
			repeat (n) begin
				b.op    = lscn_op_t'($urandom_range(3));
				b.color = $urandom_range(1);
				b.raw   = random_raws();
				offer(b);
			end
		end
	endtask

	// Receiver: stall on a pattern that changes after a random run. On request
	// hold off for a long stretch, counted here, so the sender keeps offering
	// while the output register fills and the block stalls its input.
	initial begin
		rx_mode_e rx_mode;
		int       mode_left;
		int       hold_left;
		int       tick;
		rx_mode   = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		tick      = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_e'($urandom_range(3));
					mode_left = $urandom_range(200, 20);
				end
				mode_left--;
				case (rx_mode)
				RX_FREE:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(3) == 0);
				RX_HEAVY: out_stall <= ($urandom_range(3) != 0);
				default:  out_stall <= ((tick % 8) < 5);
				endcase
			end
		end
	end

	// Check every result beat taken at an edge against the oldest one due.
	always @(posedge clk) begin : watch_levels
		level_beat_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = {level_5, level_4, level_3, level_2, level_1, level_0, line_detected};
			sb.check_result(got);
		end
	end

	initial begin
		sense_beat_t           directed[$];
		logic [LSCN_RAW_W-1:0] m;
		int                    phase;
		int                    phase_start;

		// Drive every input to a known value before the first edge.
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_NONE;
		detect_color = 1'b0;
		raw_0        = '0;
		raw_1        = '0;
		raw_2        = '0;
		raw_3        = '0;
		raw_4        = '0;
		raw_5        = '0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset margin.
		// Measure right after reset: inverted range, nothing can be detected.
		directed.push_back(mk_beat(OP_MEASURE, 1'b0, 0, 65535, 1, 32768, 65534, 4096));
		directed.push_back(mk_beat(OP_MEASURE, 1'b1, 0, 65535, 1, 32768, 65534, 4096));
		// Unused opcode leaves state alone and returns zeros.
		directed.push_back(mk_beat(OP_NONE, 1'b1, 65535, 65535, 65535, 65535, 65535, 65535));
		// A single sweep gives empty ranges everywhere.
		directed.push_back(mk_beat(OP_UPDATE, 1'b0, 1000, 0, 500, 65535, 2000, 30000));
		directed.push_back(mk_beat(OP_MEASURE, 1'b0, 1000, 0, 500, 65535, 2000, 30000));
		// Widen most channels; channel 2 stays empty.
		directed.push_back(mk_beat(OP_UPDATE, 1'b1, 5000, 65535, 500, 0, 9000, 40000));
		// Below min clamps to zero, above max to full scale.
		directed.push_back(mk_beat(OP_MEASURE, 1'b1, 0, 65535, 500, 32767, 9001, 35000));
		directed.push_back(mk_beat(OP_MEASURE, 1'b0, 65535, 0, 65535, 0, 2000, 30000));
		directed.push_back(mk_beat(OP_MEASURE, 1'b0, 3000, 30000, 500, 20000, 5500, 39999));
		// Exactly at the minimums: no black seen.
		directed.push_back(mk_beat(OP_MEASURE, 1'b1, 1000, 0, 500, 0, 2000, 30000));
		directed.push_back(mk_beat(OP_CLEAR, 1'b0, 16'hAAAA, 16'hAAAA, 16'hAAAA,
			16'hAAAA, 16'hAAAA, 16'hAAAA));
		directed.push_back(mk_beat(OP_MEASURE, 1'b1, 16'h5555, 16'h5555, 16'h5555,
			16'h5555, 16'h5555, 16'h5555));
		directed.push_back(mk_beat(OP_NONE, 1'b0, 0, 0, 0, 0, 0, 0));
		// Full timer range on every channel.
		directed.push_back(mk_beat(OP_UPDATE, 1'b0, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_beat(OP_UPDATE, 1'b1, 65535, 65535, 65535, 65535, 65535, 65535));
		directed.push_back(mk_beat(OP_MEASURE, 1'b0, 0, 65535, 32767, 32768, 1, 65534));
		directed.push_back(mk_beat(OP_MEASURE, 1'b1, 0, 65535, 32767, 32768, 1, 65534));
		directed.push_back(mk_beat(OP_CLEAR, 1'b1, 65535, 0, 65535, 0, 65535, 0));
		directed.push_back(mk_beat(OP_MEASURE, 1'b0, 65535, 0, 65535, 0, 65535, 0));
		foreach (directed[i])
			offer(directed[i]);

		// Random part: one margin per phase, the extremes among them.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
			0:       m = '0;
			1:       m = LSCN_RAW_MAX;
			2:       m = $urandom_range(2000);
			3:       m = $urandom_range(65535);
			4:       m = LSCN_MARGIN_RST;
			default: m = $urandom_range(300);
			endcase
			set_margin(m);
			// Long receiver hold-off while beats keep coming.
			if (phase == 2 || phase == 4)
				hold_req = 1'b1;
			phase_start = beats_counted;
			while (beats_counted - phase_start < PHASE_BEATS)
				run_sequence();
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d beats over %0d margin settings; %0d measures, %0d saw a line.",
			sb.results_seen, margins_written + 1, sb.measures, sb.detections);
		$display("%0d field mismatches, %0d results still owed.", sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Hard stop, far beyond the slowest correct run.
	initial begin
		#4_000_000;
		$display("Timed out with %0d results owed.", sb.pending());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// File: line_sensor_calibrate_normalize_core.f
src/lscn_pkg.sv
src/lscn_cal_store.sv
src/lscn_div.sv
src/line_sensor_calibrate_normalize_core.sv
tb/tb_line_sensor_calibrate_normalize_core.sv
